// ----- sv/tds_pkg.sv -----
// Shared types, constants and the pair-to-slot mapping of the triangular distance store.
package tds_pkg;

	localparam int MAX_SPECIES_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;
	localparam int RESULT_W = 38;
	localparam int SLOT_W   = 2 * CNT_W;
	localparam int SUM_W    = VALUE_W + CNT_W;

	localparam logic [CNT_W-1:0] COUNT_RESET   = CNT_W'(2);
	localparam logic [CNT_W-1:0] MIN_AVG_COUNT = CNT_W'(3);
	localparam logic [CNT_W-1:0] DIV_OFFSET    = CNT_W'(2);

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_AVG   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EQUAL = 2'd1,
		ST_RANGE = 2'd2,
		ST_FEW   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_AVG    = 2'd2,
		OP_ANSWER = 2'd3
	} op_kind_t;

	// One classified item as it travels from the front end to the back end.
	typedef struct packed {
		op_kind_t             kind;
		status_t              status;
		logic [IDX_W-1:0]     row;
		logic [SLOT_W-1:0]    slot;
		logic [VALUE_W-1:0]   value;
		logic [CNT_W-1:0]     count;
	} op_t;

	// Entry of the pair (a, b) in packed lower-triangular order.
	function automatic logic [SLOT_W-1:0] pair_slot(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W-1:0]  big;
		logic [CNT_W-1:0]  sml;
		logic [SLOT_W-1:0] prod;
		big  = (a > b) ? a : b;
		sml  = (a > b) ? b : a;
		prod = SLOT_W'(big) * SLOT_W'(big - CNT_W'(1));
		return (prod >> 1) + SLOT_W'(sml);
	endfunction

endpackage

// ----- sv/tds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2016
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- sv/tds_front.sv -----
// Front end: species count register, item acceptance and classification.
module tds_front #(
	parameter int MAX_SPECIES = tds_pkg::MAX_SPECIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [tds_pkg::CMD_W-1:0]     cmd,
	input  logic [tds_pkg::IDX_W-1:0]     row,
	input  logic [tds_pkg::IDX_W-1:0]     col,
	input  logic [tds_pkg::VALUE_W-1:0]   value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tds_pkg::CNT_W-1:0]     cfg_data,
	input  logic                          q_full,
	output logic                          q_push,
	output tds_pkg::op_t                  q_op
);

	logic [tds_pkg::CNT_W-1:0] n_species_q;
	logic [tds_pkg::CNT_W-1:0] live_n;
	logic [tds_pkg::CNT_W-1:0] row_ext;
	logic [tds_pkg::CNT_W-1:0] col_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_species_q <= tds_pkg::COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			n_species_q <= cfg_data;
		end
	end

	// A count above the capacity bounds indices and the average as the capacity.
	assign live_n  = (32'(n_species_q) > 32'(MAX_SPECIES)) ?
			tds_pkg::CNT_W'(MAX_SPECIES) : n_species_q;
	assign row_ext = tds_pkg::CNT_W'(row);
	assign col_ext = tds_pkg::CNT_W'(col);

	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	always_comb begin
		q_op        = '0;
		q_op.kind   = tds_pkg::OP_ANSWER;
		q_op.status = tds_pkg::ST_OK;
		q_op.row    = row;
		q_op.slot   = tds_pkg::pair_slot(row_ext, col_ext);
		q_op.value  = value;
		q_op.count  = live_n;
		case (tds_pkg::cmd_t'(cmd))
			tds_pkg::CMD_WRITE, tds_pkg::CMD_READ: begin
				if (row == col) begin
					q_op.status = tds_pkg::ST_EQUAL;
				end else if (row_ext >= live_n || col_ext >= live_n) begin
					q_op.status = tds_pkg::ST_RANGE;
				end else if (tds_pkg::cmd_t'(cmd) == tds_pkg::CMD_WRITE) begin
					q_op.kind = tds_pkg::OP_WRITE;
				end else begin
					q_op.kind = tds_pkg::OP_READ;
				end
			end
			tds_pkg::CMD_AVG: begin
				if (live_n < tds_pkg::MIN_AVG_COUNT) begin
					q_op.status = tds_pkg::ST_FEW;
				end else if (row_ext >= live_n) begin
					q_op.status = tds_pkg::ST_RANGE;
				end else begin
					q_op.kind = tds_pkg::OP_AVG;
				end
			end
			default: begin
				q_op.kind = tds_pkg::OP_ANSWER;
			end
		endcase
	end

endmodule

// ----- sv/tds_fifo.sv -----
// Short queue of classified items between the front end and the back end.
module tds_fifo #(
	parameter int DEPTH = tds_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tds_pkg::op_t  push_op,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output tds_pkg::op_t  head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tds_pkg::op_t        mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ----- sv/tds_back.sv -----
// Back end: distance memory, row summation, bit-serial divider and result register.
module tds_back #(
	parameter int MAX_SPECIES = tds_pkg::MAX_SPECIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  tds_pkg::op_t                   q_head,
	output logic                           q_pop,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [tds_pkg::RESULT_W-1:0]   result,
	output logic [tds_pkg::STATUS_W-1:0]   status
);

	localparam int STORE_DEPTH = MAX_SPECIES * (MAX_SPECIES - 1) / 2;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = tds_pkg::CNT_W;
	localparam int SUM_W       = tds_pkg::SUM_W;
	localparam int RESULT_W    = tds_pkg::RESULT_W;
	localparam int STEP_W      = $clog2(SUM_W + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_SUM  = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} back_state_t;

	back_state_t                  state_q;
	logic                         acc_vld_s1;
	logic                         rsp_valid_q;
	logic [tds_pkg::IDX_W-1:0]    row_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             idx_q;
	logic [SUM_W-1:0]             quo_q;
	logic [CNT_W-1:0]             rem_q;
	logic [STEP_W-1:0]            step_q;
	logic [RESULT_W-1:0]          pend_res_q;
	tds_pkg::status_t             pend_sts_q;
	logic [RESULT_W-1:0]          result_q;
	tds_pkg::status_t             status_q;

	logic                         wr_en;
	logic                         rd_en;
	logic [ADDR_W-1:0]            rd_addr;
	logic [tds_pkg::VALUE_W-1:0]  rd_data;
	logic                         sum_issue;
	logic                         out_free;
	logic [CNT_W-1:0]             divisor;
	logic [CNT_W:0]               trial;
	logic                         trial_ge;
	logic [CNT_W:0]               trial_diff;

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign sum_issue = (state_q == S_SUM) && (idx_q != count_q) &&
			(idx_q != CNT_W'(row_q));
	assign wr_en     = q_pop && (q_head.kind == tds_pkg::OP_WRITE);
	assign rd_en     = (q_pop && (q_head.kind == tds_pkg::OP_READ)) || sum_issue;
	assign rd_addr   = (state_q == S_SUM) ?
			ADDR_W'(tds_pkg::pair_slot(CNT_W'(row_q), idx_q)) : ADDR_W'(q_head.slot);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// One quotient bit per cycle: shift the next dividend bit into the remainder.
	assign divisor    = count_q - tds_pkg::DIV_OFFSET;
	assign trial      = {rem_q, quo_q[SUM_W-1]};
	assign trial_ge   = trial >= {1'b0, divisor};
	assign trial_diff = trial - {1'b0, divisor};

	tds_ram #(
		.WIDTH(tds_pkg::VALUE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(ADDR_W'(q_head.slot)),
		.wr_data(q_head.value),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			acc_vld_s1 <= sum_issue;
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						case (q_head.kind)
							tds_pkg::OP_READ: state_q <= S_READ;
							tds_pkg::OP_AVG:  state_q <= S_SUM;
							default:          state_q <= S_OUT;
						endcase
					end
				end
				S_READ: state_q <= S_OUT;
				S_SUM: begin
					if (idx_q == count_q) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (step_q == STEP_W'(SUM_W)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				row_q      <= q_head.row;
				count_q    <= q_head.count;
				idx_q      <= '0;
				quo_q      <= '0;
				pend_res_q <= '0;
				pend_sts_q <= q_head.status;
			end
			S_READ: begin
				pend_res_q <= RESULT_W'(rd_data);
			end
			S_SUM: begin
				// Data read in the previous cycle lands here, including the last one.
				quo_q <= quo_q + (acc_vld_s1 ? SUM_W'(rd_data) : '0);
				if (idx_q == count_q) begin
					rem_q  <= '0;
					step_q <= '0;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_DIV: begin
				if (step_q == STEP_W'(SUM_W)) begin
					pend_res_q <= (quo_q[SUM_W-1:RESULT_W] != '0) ? '1 : quo_q[RESULT_W-1:0];
				end else begin
					rem_q  <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
					quo_q  <= {quo_q[SUM_W-2:0], trial_ge};
					step_q <= step_q + STEP_W'(1);
				end
			end
			S_OUT: begin
				if (out_free) begin
					result_q <= pend_res_q;
					status_q <= pend_sts_q;
				end
			end
			default: begin
				pend_res_q <= '0;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign result    = result_q;
	assign status    = status_q;

endmodule

// ----- sv/triangular_distance_store.sv -----
// Top level of the triangular distance store.
// A write, an empty command or an item answered with an error status goes from the head of the
// two-entry queue through the back end's idle and output states; a read also passes the read
// state. A row average is summed through the single read port of the distance memory, which
// delivers one stored entry per cycle, skipping the row's own index; the sum then goes through
// a 39-step bit-serial divider. The front end keeps accepting items until the queue is full,
// and a finished result waits in the output register while the back end works on its next
// item up to that item's output state. The distance memory has no reset and no clearing pass:
// every entry must be written before a read or a row average touches it. The species count may
// be written only while the block holds no item; it is taken in the cycle its write is offered.
module triangular_distance_store #(
	parameter int MAX_SPECIES = tds_pkg::MAX_SPECIES_DEF,
	parameter int QUEUE_DEPTH = tds_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [tds_pkg::CMD_W-1:0]      cmd,
	input  logic [tds_pkg::IDX_W-1:0]      row,
	input  logic [tds_pkg::IDX_W-1:0]      col,
	input  logic [tds_pkg::VALUE_W-1:0]    value,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [tds_pkg::RESULT_W-1:0]   result,
	output logic [tds_pkg::STATUS_W-1:0]   status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tds_pkg::CNT_W-1:0]      cfg_data
);

	logic         q_full;
	logic         q_empty;
	logic         q_push;
	logic         q_pop;
	tds_pkg::op_t q_op;
	tds_pkg::op_t q_head;

	tds_front #(
		.MAX_SPECIES(MAX_SPECIES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd      (cmd),
		.row      (row),
		.col      (col),
		.value    (value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (q_op)
	);

	tds_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.push_op(q_op),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	tds_back #(
		.MAX_SPECIES(MAX_SPECIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result   (result),
		.status   (status)
	);

endmodule

// ----- sv/tds_checker.sv -----
// Port-level checks of the triangular distance store and their binding to the top level.
module tds_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_stall,
	input logic                           rsp_valid,
	input logic                           rsp_stall,
	input logic [tds_pkg::RESULT_W-1:0]   result,
	input logic [tds_pkg::STATUS_W-1:0]   status
);

	logic [7:0] outstanding_q;
	logic       req_take;
	logic       rsp_take;

	assign req_take = req_valid && !req_stall;
	assign rsp_take = rsp_valid && !rsp_stall;

	// Items accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (req_take && !rsp_take) begin
			outstanding_q <= outstanding_q + 8'd1;
		end else if (rsp_take && !req_take) begin
			outstanding_q <= outstanding_q - 8'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(result) && $stable(status))
		else $error("result changed while stalled");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != tds_pkg::ST_OK |-> result == '0)
		else $error("error result carries a nonzero value");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outstanding_q != 8'd0)
		else $error("result offered with no item outstanding");

	a_idle_open: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == 8'd0 |-> !req_stall)
		else $error("input stalled while the block holds no item");

endmodule

bind triangular_distance_store tds_checker u_tds_checker (.*);

// ----- tb/sv/tb_triangular_distance_store.sv -----
// Self-checking testbench for the packed lower-triangular distance store.
`timescale 1ns / 1ps

module tb_triangular_distance_store;

	localparam int RESULT_W = tds_pkg::RESULT_W;
	localparam int CNT_W = tds_pkg::CNT_W;
	localparam int IDX_W = tds_pkg::IDX_W;
	localparam int VALUE_W = tds_pkg::VALUE_W;
	localparam int CMD_W = tds_pkg::CMD_W;
	localparam int STATUS_W = tds_pkg::STATUS_W;
	localparam int SPECIES = tds_pkg::MAX_SPECIES_DEF;
	localparam int STORE_DEPTH = SPECIES * (SPECIES - 1) / 2;
	localparam logic [63:0] RESULT_MAX = (64'd1 << RESULT_W) - 64'd1;
	localparam int RANDOM_ITEMS = 550;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 150;
	localparam int NUM_DIRECTED = 24;

	typedef tds_pkg::cmd_t cmd_t;
	typedef tds_pkg::status_t status_t;

	typedef struct packed {
		logic [RESULT_W-1:0] res_val;
		status_t             code;
	} answer_t;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		cmd_t               op;
		logic [IDX_W-1:0]   a;
		logic [IDX_W-1:0]   b;
		logic [VALUE_W-1:0] v;
		logic               typed;
		logic [RESULT_W-1:0] res_val;
		status_t            code;
	} directed_t;

	// Rows with typed answers are checked against those; the others go through the predictor.
	localparam directed_t DIRECTED [NUM_DIRECTED] = '{
		'{7'd2, tds_pkg::CMD_AVG, 6'd0, 6'd0, 32'h0, 1'b1, 38'h0, tds_pkg::ST_FEW},
		'{7'd2, tds_pkg::CMD_WRITE, 6'd1, 6'd0, 32'hFFFF_FFFF, 1'b1, 38'h0, tds_pkg::ST_OK},
		'{7'd2, tds_pkg::CMD_READ, 6'd0, 6'd1, 32'h0, 1'b1, 38'hFFFF_FFFF, tds_pkg::ST_OK},
		'{7'd2, tds_pkg::CMD_WRITE, 6'd5, 6'd5, 32'h1234_5678, 1'b1, 38'h0, tds_pkg::ST_EQUAL},
		'{7'd2, tds_pkg::CMD_READ, 6'd2, 6'd0, 32'h0, 1'b1, 38'h0, tds_pkg::ST_RANGE},
		'{7'd2, tds_pkg::CMD_NONE, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, 38'h0, tds_pkg::ST_OK},
		'{7'd0, tds_pkg::CMD_WRITE, 6'd1, 6'd0, 32'h1, 1'b1, 38'h0, tds_pkg::ST_RANGE},
		'{7'd0, tds_pkg::CMD_READ, 6'd0, 6'd0, 32'h0, 1'b1, 38'h0, tds_pkg::ST_EQUAL},
		'{7'd0, tds_pkg::CMD_AVG, 6'd0, 6'd0, 32'h0, 1'b1, 38'h0, tds_pkg::ST_FEW},
		'{7'd1, tds_pkg::CMD_AVG, 6'd63, 6'd0, 32'h0, 1'b1, 38'h0, tds_pkg::ST_FEW},
		'{7'd3, tds_pkg::CMD_WRITE, 6'd2, 6'd0, 32'h0, 1'b1, 38'h0, tds_pkg::ST_OK},
		'{7'd3, tds_pkg::CMD_WRITE, 6'd1, 6'd2, 32'h0001_8000, 1'b1, 38'h0, tds_pkg::ST_OK},
		'{7'd3, tds_pkg::CMD_AVG, 6'd2, 6'd0, 32'h0, 1'b0, 38'h0, tds_pkg::ST_OK},
		'{7'd3, tds_pkg::CMD_AVG, 6'd0, 6'd0, 32'h0, 1'b0, 38'h0, tds_pkg::ST_OK},
		'{7'd3, tds_pkg::CMD_AVG, 6'd1, 6'd0, 32'h0, 1'b0, 38'h0, tds_pkg::ST_OK},
		'{7'd3, tds_pkg::CMD_AVG, 6'd3, 6'd0, 32'h0, 1'b1, 38'h0, tds_pkg::ST_RANGE},
		'{7'd3, tds_pkg::CMD_READ, 6'd0, 6'd3, 32'h0, 1'b1, 38'h0, tds_pkg::ST_RANGE},
		'{7'd127, tds_pkg::CMD_WRITE, 6'd63, 6'd62, 32'h8000_0000, 1'b1, 38'h0, tds_pkg::ST_OK},
		'{7'd127, tds_pkg::CMD_READ, 6'd62, 6'd63, 32'h0, 1'b1, 38'h8000_0000, tds_pkg::ST_OK},
		'{7'd127, tds_pkg::CMD_READ, 6'd63, 6'd63, 32'h0, 1'b1, 38'h0, tds_pkg::ST_EQUAL},
		'{7'd64, tds_pkg::CMD_WRITE, 6'd0, 6'd63, 32'hFFFF_FFFF, 1'b1, 38'h0, tds_pkg::ST_OK},
		'{7'd64, tds_pkg::CMD_READ, 6'd63, 6'd0, 32'h0, 1'b1, 38'hFFFF_FFFF, tds_pkg::ST_OK},
		'{7'd65, tds_pkg::CMD_READ, 6'd62, 6'd63, 32'h0, 1'b0, 38'h0, tds_pkg::ST_OK},
		'{7'd65, tds_pkg::CMD_WRITE, 6'd0, 6'd1, 32'h1, 1'b1, 38'h0, tds_pkg::ST_OK}
	};

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [CMD_W-1:0]    cmd;
	logic [IDX_W-1:0]    row;
	logic [IDX_W-1:0]    col;
	logic [VALUE_W-1:0]  value;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [RESULT_W-1:0] result;
	logic [STATUS_W-1:0] status;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data;

	logic [VALUE_W-1:0] dist_mem [STORE_DEPTH];
	bit                 written [STORE_DEPTH];
	logic [CNT_W-1:0]   held_count;
	answer_t            pending_answers [$];

	int unsigned errors;
	int unsigned items_sent;
	int unsigned averages_done;
	int unsigned error_answers;
	int unsigned settings_used;
	int unsigned sender_idle_pct;
	int unsigned receiver_idle_pct;
	int unsigned focus;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	int unsigned hold_asked;
	int unsigned hold_taken;

	triangular_distance_store DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.row       (row),
		.col       (col),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.result    (result),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		errors++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	// Counts above the capacity act as the capacity.
	function automatic int unsigned eff_count();
		return (held_count > SPECIES) ? SPECIES : int'(held_count);
	endfunction

	function automatic int unsigned slot_of(input int unsigned a, input int unsigned b);
		int unsigned big;
		int unsigned sml;
		big = (a > b) ? a : b;
		sml = (a > b) ? b : a;
		return big * (big - 1) / 2 + sml;
	endfunction

	function automatic int unsigned other_species(input int unsigned a, input int unsigned n);
		return (a + $urandom_range(1, n - 1)) % n;
	endfunction

	// Applies one item to the shadow store and returns the answer it must produce.
	function automatic answer_t compute_answer(input cmd_t op, input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b, input logic [VALUE_W-1:0] v);
		answer_t     ans;
		int unsigned n;
		int unsigned s;
		logic [63:0] total;
		ans.res_val = '0;
		ans.code = tds_pkg::ST_OK;
		n = eff_count();
		case (op)
			tds_pkg::CMD_WRITE, tds_pkg::CMD_READ: begin
				if (a == b)
					ans.code = tds_pkg::ST_EQUAL;
				else if (a >= n || b >= n)
					ans.code = tds_pkg::ST_RANGE;
				else begin
					s = slot_of(a, b);
					if (op == tds_pkg::CMD_WRITE) begin
						dist_mem[s] = v;
						written[s] = 1'b1;
					end else
						ans.res_val = RESULT_W'(dist_mem[s]);
				end
			end
			tds_pkg::CMD_AVG: begin
				if (n < 3)
					ans.code = tds_pkg::ST_FEW;
				else if (a >= n)
					ans.code = tds_pkg::ST_RANGE;
				else begin
					total = '0;
					for (int unsigned i = 0; i < n; i++)
						if (i != a)
							total += 64'(dist_mem[slot_of(a, i)]);
					total = total / 64'(n - 2);
					if (total > RESULT_MAX)
						total = RESULT_MAX;
					ans.res_val = total[RESULT_W-1:0];
					averages_done++;
				end
			end
			default: ;
		endcase
		if (ans.code != tds_pkg::ST_OK)
			error_answers++;
		return ans;
	endfunction

	task automatic send_item(input cmd_t op, input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b, input logic [VALUE_W-1:0] v,
			input logic typed, input answer_t fixed);
		answer_t ans;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= op;
		row <= a;
		col <= b;
		value <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		ans = compute_answer(op, a, b, v);
		pending_answers.push_back(typed ? fixed : ans);
		items_sent++;
	endtask

	// Always lets at least one edge pass, so valid is never lowered and raised in one step.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_answers.size() != 0);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] cnt);
		cfg_valid <= 1'b1;
		cfg_data <= cnt;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		held_count = cnt;
		settings_used++;
	endtask

	// Mostly well-formed traffic; reads and row averages only touch entries already
	// written, and a row that is not yet complete gets its missing entries written first.
	task automatic next_item(output cmd_t op, output logic [IDX_W-1:0] a,
			output logic [IDX_W-1:0] b, output logic [VALUE_W-1:0] v);
		int unsigned n;
		int unsigned pick;
		int unsigned k;
		n = eff_count();
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, 9);
		v = (k == 0) ? '0 : (k == 1) ? '1 : VALUE_W'($urandom());
		a = IDX_W'($urandom_range(0, 63));
		b = IDX_W'($urandom_range(0, 63));
		op = tds_pkg::CMD_NONE;
		if (n < 2)
			op = cmd_t'($urandom_range(0, 3));
		else if (pick < 6) begin
			if (pick < 2)
				op = tds_pkg::CMD_NONE;
			else if (pick < 4) begin
				op = (pick == 2) ? tds_pkg::CMD_READ : tds_pkg::CMD_WRITE;
				b = a;
			end else if (n < SPECIES) begin
				op = cmd_t'($urandom_range(0, 2));
				a = IDX_W'($urandom_range(n, 63));
			end
		end else if (pick < 45) begin
			op = tds_pkg::CMD_WRITE;
			a = IDX_W'((pick < 25) ? focus : $urandom_range(0, n - 1));
			b = IDX_W'(other_species(a, n));
		end else if (pick < 75) begin
			op = tds_pkg::CMD_WRITE;
			for (k = 0; k < 8; k++) begin
				a = IDX_W'($urandom_range(0, n - 1));
				b = IDX_W'(other_species(a, n));
				if (written[slot_of(a, b)]) begin
					op = tds_pkg::CMD_READ;
					break;
				end
			end
		end else begin
			op = tds_pkg::CMD_AVG;
			a = IDX_W'((pick < 90) ? focus : $urandom_range(0, n - 1));
			if (n >= 3)
				for (k = 0; k < n; k++)
					if (k != a && !written[slot_of(a, k)]) begin
						op = tds_pkg::CMD_WRITE;
						b = IDX_W'(k);
						break;
					end
		end
	endtask

	always @(posedge clk) begin : answer_side
		answer_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_answers.size() == 0)
				flag_error($sformatf("result %h status %0d with nothing expected",
					result, status));
			else begin
				want = pending_answers.pop_front();
				if (result !== want.res_val)
					flag_error($sformatf("result %h, expected %h", result, want.res_val));
				if (status !== want.code)
					flag_error($sformatf("status %0d, expected %0d", status, want.code));
			end
		end
		if (hold_asked != hold_taken) begin
			hold_left = HOLD_CYCLES;
			hold_taken = hold_asked;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles, %0d items outstanding",
					QUIET_LIMIT, pending_answers.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		cmd_t                op;
		logic [IDX_W-1:0]    a;
		logic [IDX_W-1:0]    b;
		logic [VALUE_W-1:0]  v;
		logic [CNT_W-1:0]    cnt;
		answer_t             fixed;
		int unsigned         seg;
		int unsigned         seg_len;
		int unsigned         random_sent;
		arst_n = 1'b0;
		req_valid = 1'b0;
		cmd = tds_pkg::CMD_NONE;
		row = '0;
		col = '0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		held_count = tds_pkg::COUNT_RESET;
		sender_idle_pct = 17;
		receiver_idle_pct = 85;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < NUM_DIRECTED; k++) begin
			if (DIRECTED[k].count != held_count) begin
				wait_drained();
				write_count(DIRECTED[k].count);
			end
			fixed.res_val = DIRECTED[k].res_val;
			fixed.code = DIRECTED[k].code;
			send_item(DIRECTED[k].op, DIRECTED[k].a, DIRECTED[k].b, DIRECTED[k].v,
				DIRECTED[k].typed, fixed);
		end

		seg = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			wait_drained();
			if (seg == 2)
				cnt = CNT_W'(SPECIES);
			else if (seg == 5)
				cnt = '1;
			else
				case ($urandom_range(0, 9))
					0: cnt = CNT_W'($urandom_range(0, 2));
					1: cnt = CNT_W'($urandom_range(SPECIES + 1, 127));
					2, 3: cnt = CNT_W'($urandom_range(11, SPECIES - 1));
					default: cnt = CNT_W'($urandom_range(3, 10));
				endcase
			write_count(cnt);
			focus = (eff_count() > 0) ? $urandom_range(0, eff_count() - 1) : 0;
			seg_len = (cnt >= 11) ? 100 : $urandom_range(15, 40);
			// The receiver backs off for a long stretch while items keep coming.
			if (seg == 1)
				hold_asked++;
			for (int unsigned j = 0; j < seg_len && random_sent < RANDOM_ITEMS; j++) begin
				if (random_sent < RANDOM_ITEMS / 3) begin
					sender_idle_pct = 17;
					receiver_idle_pct = 85;
				end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
					sender_idle_pct = 85;
					receiver_idle_pct = 17;
				end else begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
				end
				if (seg == 3 && j == 10)
					wait_drained();
				next_item(op, a, b, v);
				send_item(op, a, b, v, 1'b0, '0);
				random_sent++;
			end
			seg++;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_answers.size()));
		$display("Sent %0d items over %0d species-count settings: %0d row averages, %0d errors.",
			items_sent, settings_used, averages_done, error_answers);
		$display("Idle patterns: sender-heavy, receiver-heavy, none; one long receiver hold.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
